// ===== sv/pagt_pkg.sv =====
// Package with shared constants and the fixed-point cosine coefficient helper.
package pagt_pkg;

    localparam int MaxLinksDefault = 4;
    localparam int AngleBitsDefault = 16;
    localparam int CosFracDefault = 15;
    localparam int WeightBits = 24;
    localparam int LenBits = 20;
    localparam int TorqueBits = 36;
    localparam int ParamBits = 64;
    localparam int CfgIndexBits = 4;
    localparam int ActiveBits = 4;
    localparam logic [CfgIndexBits-1:0] CfgActiveLinks = 4'd0;

    localparam logic signed [31:0] PolyC0 = 32'sd1073741824;
    localparam logic signed [31:0] PolyC1 = 32'sd1324675879;
    localparam logic signed [31:0] PolyC2 = 32'sd272375560;
    localparam logic signed [31:0] PolyC3 = 32'sd22401992;
    localparam logic signed [31:0] PolyC4 = 32'sd987048;
    localparam logic signed [31:0] PolyC5 = 32'sd27060;
    localparam logic signed [31:0] PolyC6 = 32'sd506;

    // Signed coefficient applied after each Horner product, highest step first.
    function automatic logic signed [31:0] horner_coef(input logic [2:0] step);
        logic signed [31:0] c;
        begin
            case (step)
                3'd0: c = -PolyC5;
                3'd1: c = PolyC4;
                3'd2: c = -PolyC3;
                3'd3: c = PolyC2;
                3'd4: c = -PolyC1;
                default: c = PolyC0;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== sv/pagt_cell.sv =====
// One link cell: running angle sum, cosine pipeline and lever terms for one link.
module pagt_cell #(
    parameter int ANGLE_BITS = pagt_pkg::AngleBitsDefault,
    parameter int COSINE_FRAC_BITS = pagt_pkg::CosFracDefault
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [ANGLE_BITS-1:0]              angle_sum_in,
    input  logic [ANGLE_BITS-1:0]              joint_angle,
    input  logic [pagt_pkg::LenBits-1:0]       length,
    input  logic [pagt_pkg::LenBits-1:0]       com,
    output logic [ANGLE_BITS-1:0]              angle_sum_out,
    output logic signed [pagt_pkg::LenBits+COSINE_FRAC_BITS+2:0] len_term,
    output logic signed [pagt_pkg::LenBits+COSINE_FRAC_BITS+2:0] com_term
);
    import pagt_pkg::*;

    localparam int PipeSteps = 6;
    localparam int CosBits = COSINE_FRAC_BITS + 2;
    localparam int TermBits = LenBits + CosBits + 1;

    logic [ANGLE_BITS-1:0] abs_angle;
    logic [1:0]            quad;
    logic [ANGLE_BITS-2:0] xval;
    logic [31:0]           tval;
    logic [63:0]           tsq;

    logic signed [31:0]    v_reg [PipeSteps+1];
    logic signed [31:0]    acc_reg [PipeSteps+1];
    logic [1:0]            quad_reg [PipeSteps+1];
    logic [LenBits-1:0]    len_reg [PipeSteps+2];
    logic [LenBits-1:0]    com_reg [PipeSteps+2];
    logic signed [CosBits-1:0] cos_reg;
    logic signed [63:0]    prod [PipeSteps];
    logic signed [31:0]    acc_clamp;
    logic [31:0]           acc_round;
    logic signed [CosBits-1:0] cos_next;

    assign abs_angle = angle_sum_in + joint_angle;
    assign angle_sum_out = abs_angle;
    assign quad = abs_angle[ANGLE_BITS-1 -: 2];
    always_comb
    begin
        if (quad[0])
            xval = (ANGLE_BITS-1)'({1'b1, {(ANGLE_BITS-2){1'b0}}} - {1'b0, abs_angle[ANGLE_BITS-3:0]});
        else
            xval = {1'b0, abs_angle[ANGLE_BITS-3:0]};
    end
    assign tval = 32'(xval) << (32 - ANGLE_BITS);
    assign tsq = 64'(tval) * 64'(tval);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0] <= 32'(tsq >> 30);
            acc_reg[0] <= PolyC6;
            quad_reg[0] <= quad;
            len_reg[0] <= length;
            com_reg[0] <= com;
        end
    end

    for (genvar s = 0; s < PipeSteps; s++) begin : g_horner
        assign prod[s] = (64'(acc_reg[s]) * 64'(v_reg[s])) / 64'sd1073741824;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s+1] <= 32'(prod[s]) + horner_coef(3'(s));
                v_reg[s+1] <= v_reg[s];
                quad_reg[s+1] <= quad_reg[s];
                len_reg[s+1] <= len_reg[s];
                com_reg[s+1] <= com_reg[s];
            end
        end
    end

    always_comb
    begin
        if (acc_reg[PipeSteps] < 0)
            acc_clamp = '0;
        else if (acc_reg[PipeSteps] > PolyC0)
            acc_clamp = PolyC0;
        else
            acc_clamp = acc_reg[PipeSteps];
        acc_round = (32'(acc_clamp) + (32'd1 << (29 - COSINE_FRAC_BITS)))
                    >> (30 - COSINE_FRAC_BITS);
        if (quad_reg[PipeSteps] == 2'd1 || quad_reg[PipeSteps] == 2'd2)
            cos_next = -CosBits'(acc_round);
        else
            cos_next = CosBits'(acc_round);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            len_reg[PipeSteps+1] <= len_reg[PipeSteps];
            com_reg[PipeSteps+1] <= com_reg[PipeSteps];
            len_term <= TermBits'($signed({1'b0, len_reg[PipeSteps+1]}) * cos_reg);
            com_term <= TermBits'($signed({1'b0, com_reg[PipeSteps+1]}) * cos_reg);
        end
    end
endmodule

// ===== sv/pagt_torque.sv =====
// Torque stage: levers, weighted link contributions and per-joint sums.
module pagt_torque #(
    parameter int MAX_LINKS = pagt_pkg::MaxLinksDefault,
    parameter int COSINE_FRAC_BITS = pagt_pkg::CosFracDefault
) (
    input  logic clk,
    input  logic en,
    input  logic signed [pagt_pkg::LenBits+COSINE_FRAC_BITS+2:0] len_term [MAX_LINKS],
    input  logic signed [pagt_pkg::LenBits+COSINE_FRAC_BITS+2:0] com_term [MAX_LINKS],
    input  logic [pagt_pkg::WeightBits-1:0] weight [MAX_LINKS],
    input  logic [pagt_pkg::ActiveBits-1:0] active,
    output logic signed [pagt_pkg::TorqueBits-1:0] torque [MAX_LINKS]
);
    import pagt_pkg::*;

    localparam int Shift = 16 + COSINE_FRAC_BITS;
    localparam int LevBits = LenBits + COSINE_FRAC_BITS + 6;
    localparam int MagBits = LevBits;
    localparam int ContBits = 48;

    logic signed [LevBits-1:0]  lever_reg [MAX_LINKS][MAX_LINKS];
    logic signed [ContBits-1:0] cont_reg [MAX_LINKS][MAX_LINKS];
    logic [ActiveBits-1:0]      act_reg [2];

    // Stage one: lever of link k seen from joint i.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_reg[0] <= active;
            act_reg[1] <= act_reg[0];
            for (int i = 0; i < MAX_LINKS; i++)
            begin
                for (int k = 0; k < MAX_LINKS; k++)
                begin
                    logic signed [LevBits-1:0] lv;
                    lv = LevBits'(com_term[k]);
                    for (int m = 0; m < MAX_LINKS; m++)
                        if (m >= i && m < k)
                            lv = lv + LevBits'(len_term[m]);
                    lever_reg[i][k] <= lv;
                end
            end
        end
    end

    // Stage two: weight times lever magnitude, scaled with truncation toward zero.
    for (genvar i = 0; i < MAX_LINKS; i++) begin : g_row
        for (genvar k = 0; k < MAX_LINKS; k++) begin : g_col
            logic [MagBits-1:0] mag;
            logic [MagBits+WeightBits-1:0] wprod;
            logic [ContBits-1:0] scaled;
            assign mag = lever_reg[i][k][LevBits-1] ? MagBits'(-lever_reg[i][k])
                                                    : MagBits'(lever_reg[i][k]);
            assign wprod = (MagBits+WeightBits)'(mag) * (MagBits+WeightBits)'(weight[k]);
            assign scaled = ContBits'(wprod >> Shift);
            always_ff @(posedge clk)
            begin
                if (en)
                    cont_reg[i][k] <= lever_reg[i][k][LevBits-1] ? -$signed(scaled)
                                                                  : $signed(scaled);
            end
        end
    end

    // Stage three: sum the active links for each joint.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < MAX_LINKS; i++)
            begin
                logic signed [ContBits-1:0] s;
                s = '0;
                for (int k = 0; k < MAX_LINKS; k++)
                    if (k >= i && k < int'(act_reg[1]))
                        s = s + cont_reg[i][k];
                torque[i] <= TorqueBits'(s);
            end
        end
    end
endmodule

// ===== sv/planar_arm_gravity_torque.sv =====
// Top level of the planar arm gravity torque pipeline.
// Gravity torque for a planar serial arm with up to MAX_LINKS links.
// The input channel carries one set of joint angles per request (in_valid,
// in_stall); the output channel returns one set of joint torques per request
// (out_valid, out_stall). Both sides accept when valid is high and stall low.
// One request may be accepted every cycle unless the pipeline is held. The
// pipeline is a row of link cells, each adding its joint angle to the running
// sum from its neighbor and evaluating the cosine through a six step Horner
// chain, followed by lever, weight and sum stages. When a valid output is
// stalled the whole pipeline holds, and in_stall rises, so no request is lost.
// Reset clears all valid flags, sets active_links to 4 and link parameters
// to zero. Configuration writes via cfg_valid, cfg_ready, cfg_index and
// cfg_data are always ready and must occur while the block is idle. Joints at
// or beyond active_links report zero torque.
module planar_arm_gravity_torque #(
    parameter int MAX_LINKS = pagt_pkg::MaxLinksDefault,
    parameter int ANGLE_BITS = pagt_pkg::AngleBitsDefault,
    parameter int COSINE_FRAC_BITS = pagt_pkg::CosFracDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] joint_angle_0,
    input  logic signed [15:0] joint_angle_1,
    input  logic signed [15:0] joint_angle_2,
    input  logic signed [15:0] joint_angle_3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [35:0] gravity_torque_0,
    output logic signed [35:0] gravity_torque_1,
    output logic signed [35:0] gravity_torque_2,
    output logic signed [35:0] gravity_torque_3,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pagt_pkg::CfgIndexBits-1:0] cfg_index,
    input  logic [pagt_pkg::ParamBits-1:0]    cfg_data
);
    import pagt_pkg::*;

    localparam int Latency = 12;
    localparam int TermBits = LenBits + COSINE_FRAC_BITS + 3;
    localparam int Ports = 4;

    logic [ActiveBits-1:0] active_reg;
    logic [ParamBits-1:0]  params_reg [MAX_LINKS];
    logic [Latency-1:0]    valid_reg;
    logic                  en;

    logic [15:0]           ja [Ports];
    logic [ANGLE_BITS-1:0] sums [MAX_LINKS+1];
    logic [ANGLE_BITS-1:0] jsel [MAX_LINKS];
    logic signed [TermBits-1:0] len_term [MAX_LINKS];
    logic signed [TermBits-1:0] com_term [MAX_LINKS];
    logic [WeightBits-1:0] weight [MAX_LINKS];
    logic signed [TorqueBits-1:0] torque [MAX_LINKS];
    logic [ActiveBits-1:0] act_eff;

    assign en = !(out_valid && out_stall);
    assign in_stall = !en;
    assign out_valid = valid_reg[Latency-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[Latency-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ActiveBits'(4);
            for (int k = 0; k < MAX_LINKS; k++)
                params_reg[k] <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CfgActiveLinks)
                active_reg <= cfg_data[ActiveBits-1:0];
            else
                for (int k = 0; k < MAX_LINKS; k++)
                    if (int'(cfg_index) == k + 1)
                        params_reg[k] <= cfg_data;
        end
    end

    assign act_eff = (int'(active_reg) > MAX_LINKS) ? ActiveBits'(MAX_LINKS) : active_reg;

    assign ja[0] = joint_angle_0;
    assign ja[1] = joint_angle_1;
    assign ja[2] = joint_angle_2;
    assign ja[3] = joint_angle_3;
    assign sums[0] = '0;

    for (genvar k = 0; k < MAX_LINKS; k++) begin : g_cell
        assign jsel[k] = (k < Ports) ? ANGLE_BITS'(ja[k % Ports]) : '0;
        assign weight[k] = params_reg[k][63:40];
        pagt_cell #(
            .ANGLE_BITS(ANGLE_BITS),
            .COSINE_FRAC_BITS(COSINE_FRAC_BITS)
        ) u_cell (
            .clk(clk),
            .en(en),
            .angle_sum_in(sums[k]),
            .joint_angle(jsel[k]),
            .length(params_reg[k][39:20]),
            .com(params_reg[k][19:0]),
            .angle_sum_out(sums[k+1]),
            .len_term(len_term[k]),
            .com_term(com_term[k])
        );
    end

    pagt_torque #(
        .MAX_LINKS(MAX_LINKS),
        .COSINE_FRAC_BITS(COSINE_FRAC_BITS)
    ) u_torque (
        .clk(clk),
        .en(en),
        .len_term(len_term),
        .com_term(com_term),
        .weight(weight),
        .active(act_eff),
        .torque(torque)
    );

    assign gravity_torque_0 = torque[0];
    assign gravity_torque_1 = (MAX_LINKS > 1) ? torque[1 % MAX_LINKS] : '0;
    assign gravity_torque_2 = (MAX_LINKS > 2) ? torque[2 % MAX_LINKS] : '0;
    assign gravity_torque_3 = (MAX_LINKS > 3) ? torque[3 % MAX_LINKS] : '0;
endmodule
